// ===== rtl/point_transform_perspective_divide_top_defines.svh =====
// ---------------------------------------------------------------------------
// Point transform assertion macros
// Shared concurrent assertion forms, clocked on clk_i and idle in reset.
// ---------------------------------------------------------------------------
`ifndef POINT_TRANSFORM_PERSPECTIVE_DIVIDE_TOP_DEFINES_SVH
`define POINT_TRANSFORM_PERSPECTIVE_DIVIDE_TOP_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define PTPD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must be followed by a consequence in the next cycle.
`define PTPD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ptpd_pkg.sv =====
// ---------------------------------------------------------------------------
// Point transform package
// Fixed-point format, pipeline depths, register map and shared types.
// ---------------------------------------------------------------------------
`default_nettype none

package ptpd_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int NUM_REGS   = 8;
  localparam int CFG_IDX_W  = 4;
  localparam int ROW_LAT    = 4;
  localparam int DIV_STAGES = 32;
  // Row pipeline, divider entry stage, divider stages.
  localparam int PIPE_DEPTH = ROW_LAT + 1 + DIV_STAGES;

  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;
  localparam logic [63:0] ONE_LO = 64'(1) << FRAC_BITS;
  localparam logic [63:0] ONE_HI = ONE_LO << 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COL0_XY = 4'd0,
    REG_COL0_ZW = 4'd1,
    REG_COL1_XY = 4'd2,
    REG_COL1_ZW = 4'd3,
    REG_COL2_XY = 4'd4,
    REG_COL2_ZW = 4'd5,
    REG_COL3_XY = 4'd6,
    REG_COL3_ZW = 4'd7
  } cfg_reg_e;

  // Identity matrix.
  localparam logic [63:0] MAT_RESET [NUM_REGS] = '{
    ONE_LO, 64'd0, ONE_HI, 64'd0, 64'd0, ONE_LO, 64'd0, ONE_HI
  };

  typedef struct packed {
    logic        neg;
    logic [63:0] mag;
  } row_res_t;

  typedef struct packed {
    logic [31:0] value;
    logic        sat;
    logic        dz;
  } lane_res_t;

endpackage

`default_nettype wire

// ===== rtl/ptpd_intf.sv =====
// ---------------------------------------------------------------------------
// Point transform channels
// Input point, result and configuration write channels.
// ---------------------------------------------------------------------------
`default_nettype none

interface ptpd_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] in_x;
  logic signed [31:0] in_y;
  logic signed [31:0] in_z;
  modport source (output valid, in_x, in_y, in_z, input ready);
  modport sink (input valid, in_x, in_y, in_z, output ready);
endinterface

interface ptpd_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic               divide_by_zero;
  logic               saturated;
  modport source (output valid, out_x, out_y, out_z, divide_by_zero, saturated,
                  input ready);
  modport sink (input valid, out_x, out_y, out_z, divide_by_zero, saturated,
                output ready);
endinterface

interface ptpd_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/point_transform_perspective_divide_top.sv =====
// ---------------------------------------------------------------------------
// Point transform with perspective divide
// Q16.16 4x4 homogeneous transform of (x, y, z, 1) followed by division by w.
// ---------------------------------------------------------------------------
// The block accepts one point per clock cycle while the result channel is not
// stalled. Each accepted point passes through the row multiply and adder tree
// registers, one divider entry stage, the restoring divider stages (one
// quotient bit per stage), and the output register. When the result channel
// is stalled the whole pipeline holds, and input ready drops until the output
// register is taken.
// Configuration writes are accepted at any time and apply to points accepted
// afterwards; indexes beyond the eight registers are ignored.
`default_nettype none
`include "point_transform_perspective_divide_top_defines.svh"

module point_transform_perspective_divide_top
  import ptpd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  ptpd_in_if.sink    pt_i,
  ptpd_cfg_if.sink   cfg_i,
  ptpd_out_if.source res_o
);

  logic [63:0]         mat_q [NUM_REGS];
  logic [PIPE_DEPTH-1:0] vpipe_q;
  logic                out_valid_q;
  logic signed [31:0]  out_x_q, out_y_q, out_z_q;
  logic                out_dz_q, out_sat_q;
  logic                en;
  logic                in_fire;
  logic signed [31:0]  coef [4][4];
  row_res_t            row_res [4];
  lane_res_t           lane_res [3];

  assign en      = !out_valid_q || res_o.ready;
  assign in_fire = pt_i.valid && en;
  assign pt_i.ready  = en;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_q <= MAT_RESET;
    end else if (cfg_i.valid && (cfg_i.index <= REG_COL3_ZW)) begin
      mat_q[cfg_i.index[2:0]] <= cfg_i.data;
    end
  end

  // Entry 4c + r sits in register 2c + r/2, low half for even r.
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        coef[r][c] = (r % 2 == 1) ? mat_q[2*c + r/2][63:32] : mat_q[2*c + r/2][31:0];
      end
    end
  end

  for (genvar r = 0; r < 4; r++) begin : g_row
    ptpd_row u_row (
      .clk_i  (clk_i),
      .en_i   (en),
      .coef_i (coef[r]),
      .x_i    (pt_i.in_x),
      .y_i    (pt_i.in_y),
      .z_i    (pt_i.in_z),
      .res_o  (row_res[r])
    );
  end

  for (genvar r = 0; r < 3; r++) begin : g_div
    ptpd_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (row_res[r]),
      .den_i (row_res[3]),
      .res_o (lane_res[r])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vpipe_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vpipe_q     <= {vpipe_q[PIPE_DEPTH-2:0], pt_i.valid};
      out_valid_q <= vpipe_q[PIPE_DEPTH-1];
    end
  end

  // Lanes merge here: the zero-w flag comes from one lane, saturation from all.
  always_ff @(posedge clk_i) begin
    if (en && vpipe_q[PIPE_DEPTH-1]) begin
      out_x_q   <= lane_res[0].value;
      out_y_q   <= lane_res[1].value;
      out_z_q   <= lane_res[2].value;
      out_dz_q  <= lane_res[0].dz;
      out_sat_q <= lane_res[0].sat | lane_res[1].sat | lane_res[2].sat;
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.out_x          = out_x_q;
  assign res_o.out_y          = out_y_q;
  assign res_o.out_z          = out_z_q;
  assign res_o.divide_by_zero = out_dz_q;
  assign res_o.saturated      = out_sat_q;

  `PTPD_ASSERT_NEXT(a_accept_enters, in_fire, vpipe_q[0], "accepted point not in pipeline")
  `PTPD_ASSERT_NEXT(a_stall_holds, out_valid_q && !res_o.ready, out_valid_q, "result lost")
  `PTPD_ASSERT(a_dz_sat, out_valid_q && out_dz_q |-> out_sat_q, "zero w without saturation")
  `PTPD_ASSERT(a_dz_extreme, out_valid_q && out_dz_q |-> (out_x_q == Q_MAX || out_x_q == Q_MIN), "zero w x not clipped")

endmodule

`default_nettype wire

// ===== rtl/ptpd_row.sv =====
// ---------------------------------------------------------------------------
// Point transform row lane
// One matrix row times (x, y, z, 1): products, adder tree, sign and magnitude.
// ---------------------------------------------------------------------------
`default_nettype none

module ptpd_row
  import ptpd_pkg::*;
(
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [31:0] coef_i [4],
  input  logic signed [31:0] x_i,
  input  logic signed [31:0] y_i,
  input  logic signed [31:0] z_i,
  output row_res_t           res_o
);

  logic signed [63:0] prod_q [4];
  logic signed [64:0] pair_q [2];
  logic signed [65:0] sum_q;
  row_res_t           res_q;
  logic [65:0]        abs_d;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q[0] <= coef_i[0] * x_i;
      prod_q[1] <= coef_i[1] * y_i;
      prod_q[2] <= coef_i[2] * z_i;
      // Translation term times w = 1.0.
      prod_q[3] <= {{(32-FRAC_BITS){coef_i[3][31]}}, coef_i[3], {FRAC_BITS{1'b0}}};
      pair_q[0] <= 65'(prod_q[0]) + 65'(prod_q[1]);
      pair_q[1] <= 65'(prod_q[2]) + 65'(prod_q[3]);
      sum_q     <= 66'(pair_q[0]) + 66'(pair_q[1]);
      res_q.neg <= sum_q[65];
      res_q.mag <= abs_d[63:0];
    end
  end

  assign abs_d = sum_q[65] ? (66'd0 - sum_q) : sum_q;
  assign res_o = res_q;

endmodule

`default_nettype wire

// ===== rtl/ptpd_div.sv =====
// ---------------------------------------------------------------------------
// Point transform divider lane
// Pipelined restoring divide of (num << FRAC_BITS) by w, one bit per stage.
// ---------------------------------------------------------------------------
`default_nettype none

module ptpd_div
  import ptpd_pkg::*;
(
  input  logic      clk_i,
  input  logic      en_i,
  input  row_res_t  num_i,
  input  row_res_t  den_i,
  output lane_res_t res_o
);

  logic [63:0] r_q   [DIV_STAGES+1];
  logic [31:0] lo_q  [DIV_STAGES+1];
  logic [31:0] q_q   [DIV_STAGES+1];
  logic [63:0] d_q   [DIV_STAGES+1];
  logic        neg_q [DIV_STAGES+1];
  logic        ovf_q [DIV_STAGES+1];

  logic [95:0] lim_d;
  logic [63+FRAC_BITS:0] n_d;
  logic [31:0] q_fin;

  // The quotient reaches 2^32 exactly when num >= w << (32 - FRAC_BITS).
  // A zero w always lands here, which yields the saturated zero-w results.
  assign lim_d = {32'd0, den_i.mag} << (32 - FRAC_BITS);
  assign n_d   = {num_i.mag, {FRAC_BITS{1'b0}}};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ovf_q[0] <= {32'd0, num_i.mag} >= lim_d;
      neg_q[0] <= num_i.neg ^ den_i.neg;
      r_q[0]   <= 64'(n_d[63+FRAC_BITS:32]);
      lo_q[0]  <= n_d[31:0];
      q_q[0]   <= '0;
      d_q[0]   <= den_i.mag;
    end
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [64:0] t_d;
    logic        ge_d;
    assign t_d  = {r_q[k], lo_q[k][31]};
    assign ge_d = t_d >= {1'b0, d_q[k]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k+1]   <= ge_d ? 64'(t_d - {1'b0, d_q[k]}) : t_d[63:0];
        lo_q[k+1]  <= {lo_q[k][30:0], 1'b0};
        q_q[k+1]   <= {q_q[k][30:0], ge_d};
        d_q[k+1]   <= d_q[k];
        neg_q[k+1] <= neg_q[k];
        ovf_q[k+1] <= ovf_q[k];
      end
    end
  end

  assign q_fin = q_q[DIV_STAGES];

  always_comb begin
    res_o.dz    = d_q[DIV_STAGES] == 64'd0;
    res_o.sat   = 1'b0;
    res_o.value = q_fin;
    if (ovf_q[DIV_STAGES]) begin
      res_o.sat   = 1'b1;
      res_o.value = neg_q[DIV_STAGES] ? Q_MIN : Q_MAX;
    end else if (!neg_q[DIV_STAGES]) begin
      if (q_fin[31]) begin
        res_o.sat   = 1'b1;
        res_o.value = Q_MAX;
      end
    end else if (q_fin > Q_MIN) begin
      res_o.sat   = 1'b1;
      res_o.value = Q_MIN;
    end else begin
      res_o.value = 32'd0 - q_fin;
    end
  end

endmodule

`default_nettype wire
